/* sv/chd_pkg.sv */
// Shared types, constants and per-byte decode functions for the chunked decoder.
package chd_pkg;

	localparam int unsigned LEN_BITS = 32;

	localparam logic [7:0] CH_CR   = 8'h0D;
	localparam logic [7:0] CH_LF   = 8'h0A;
	localparam logic [7:0] CH_SEMI = 8'h3B;

	localparam logic OP_BYTE = 1'b0;
	localparam logic OP_END  = 1'b1;

	localparam logic KIND_DATA   = 1'b0;
	localparam logic KIND_STATUS = 1'b1;

	typedef enum logic [2:0] {
		PH_START   = 3'd0,
		PH_LINE    = 3'd1,
		PH_LINE_CR = 3'd2,
		PH_DATA    = 3'd3,
		PH_DATA_CR = 3'd4,
		PH_DATA_LF = 3'd5,
		PH_FINAL   = 3'd6
	} phase_t;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_MALFORMED = 3'd1,
		ST_INVALID   = 3'd2,
		ST_BAD_FINAL = 3'd3,
		ST_TRUNCATED = 3'd4,
		ST_NO_TERM   = 3'd5,
		ST_NO_FINAL  = 3'd6
	} status_t;

	typedef struct packed {
		phase_t              phase;
		logic [LEN_BITS-1:0] chunk_remaining;
		logic                digit_seen;
		logic                line_bad;
		logic                in_extension;
		logic [2:0]          trailer_match;
		logic [1:0]          trailer_count;
		status_t             error_code;
	} dec_state_t;

	typedef struct packed {
		logic       vld;
		logic       kind;
		logic [7:0] out_byte;
		status_t    status;
	} dec_result_t;

	typedef struct packed {
		logic       ok;
		logic [3:0] digit;
	} hex_t;

	localparam dec_state_t STATE_RESET = '{
		phase:           PH_START,
		chunk_remaining: '0,
		digit_seen:      1'b0,
		line_bad:        1'b0,
		in_extension:    1'b0,
		trailer_match:   3'd0,
		trailer_count:   2'd0,
		error_code:      ST_OK
	};

	function automatic hex_t hex_value(input logic [7:0] b);
		hex_t h;
		h.ok    = 1'b1;
		h.digit = 4'd0;
		if (b >= 8'h30 && b <= 8'h39) begin
			h.digit = 4'(b - 8'h30);
		end else if (b >= 8'h61 && b <= 8'h66) begin
			h.digit = 4'(b - 8'h57);
		end else if (b >= 8'h41 && b <= 8'h46) begin
			h.digit = 4'(b - 8'h37);
		end else begin
			h.ok = 1'b0;
		end
		return h;
	endfunction

	function automatic dec_state_t line_byte(input dec_state_t s, input logic [7:0] b);
		dec_state_t n;
		hex_t h;
		n = s;
		h = hex_value(b);
		if (b == CH_CR) begin
			n.phase = PH_LINE_CR;
		end else begin
			n.phase = PH_LINE;
			if (!s.in_extension) begin
				if (b == CH_SEMI) begin
					n.in_extension = 1'b1;
				end else if (!h.ok) begin
					n.line_bad = 1'b1;
				end else begin
					n.digit_seen = 1'b1;
					if (!s.line_bad) begin
						if (s.chunk_remaining[LEN_BITS-1 -: 4] != 4'd0) begin
							n.line_bad = 1'b1;
						end else begin
							n.chunk_remaining = {s.chunk_remaining[LEN_BITS-5:0], h.digit};
						end
					end
				end
			end
		end
		return n;
	endfunction

	function automatic dec_state_t close_size_line(input dec_state_t s);
		dec_state_t n;
		n = s;
		if (s.line_bad || !s.digit_seen) begin
			n.error_code = ST_INVALID;
		end else if (s.chunk_remaining == '0) begin
			n.phase         = PH_FINAL;
			n.trailer_match = 3'd0;
			n.trailer_count = 2'd0;
		end else begin
			n.phase = PH_DATA;
		end
		n.digit_seen   = 1'b0;
		n.line_bad     = 1'b0;
		n.in_extension = 1'b0;
		return n;
	endfunction

	function automatic dec_state_t final_byte(input dec_state_t s, input logic [7:0] b);
		dec_state_t n;
		logic [2:0] m;
		n = s;
		m = s.trailer_match;
		if (m >= 3'd4) begin
			n.error_code = ST_BAD_FINAL;
		end else begin
			if (m == 3'd1 || m == 3'd3) begin
				m = (b == CH_LF) ? m + 3'd1 : ((b == CH_CR) ? 3'd1 : 3'd0);
			end else begin
				m = (b == CH_CR) ? m + 3'd1 : 3'd0;
			end
			n.trailer_match = m;
			if (s.trailer_count != 2'd3) begin
				n.trailer_count = s.trailer_count + 2'd1;
			end
		end
		return n;
	endfunction

	function automatic status_t end_status(input dec_state_t s);
		status_t st;
		if (s.error_code != ST_OK) begin
			st = s.error_code;
		end else begin
			unique case (s.phase)
				PH_START:              st = ST_NO_FINAL;
				PH_LINE, PH_LINE_CR:   st = ST_MALFORMED;
				PH_DATA:               st = ST_TRUNCATED;
				PH_DATA_CR, PH_DATA_LF: st = ST_NO_TERM;
				PH_FINAL: begin
					if (s.trailer_match == 3'd4 ||
					    (s.trailer_match == 3'd2 && s.trailer_count == 2'd2)) begin
						st = ST_OK;
					end else begin
						st = ST_BAD_FINAL;
					end
				end
				default:               st = ST_MALFORMED;
			endcase
		end
		return st;
	endfunction

endpackage

/* sv/chd_in_if.sv */
// Input word channel: op and data byte with valid/ready.
interface chd_in_if;
	logic       valid;
	logic       ready;
	logic       op;
	logic [7:0] data_byte;

	modport source (output valid, output op, output data_byte, input ready);
	modport sink (input valid, input op, input data_byte, output ready);
endinterface

/* sv/chd_out_if.sv */
// Output word channel: decoded byte or final status with valid/ready.
interface chd_out_if;
	logic       valid;
	logic       ready;
	logic       kind;
	logic [7:0] out_byte;
	logic [2:0] status;

	modport source (output valid, output kind, output out_byte, output status, input ready);
	modport sink (input valid, input kind, input out_byte, input status, output ready);
endinterface

/* sv/http_chunked_decoder_unit.sv */
// Streaming HTTP/1.1 chunked body decoder, one input word per cycle while dout is not stalled.
//
// din carries payload words: op 0 with a raw body byte, op 1 as the end-of-payload marker.
// dout carries results: kind 0 with a decoded chunk data byte, kind 1 with the final
// status (0 ok, 1 malformed size, 2 invalid size, 3 bad final, 4 truncated,
// 5 no terminator, 6 no final). Size lines, extensions, CRLFs and trailers give no word.
// The first error is latched; later payload bytes are dropped until the end marker,
// which reports the status and restarts the decoder.
// Throughput: one input word per cycle while dout is not stalled, set by the state update in the
// decoder core. A result appears on dout in the cycle after its input word is taken.
// din.ready is high while the output register is empty or being drained this cycle,
// so a stalled receiver holds the pending word and stops intake after one word.
// Reset (arst_n low) clears the decoder to the start of a size line and empties dout.
module http_chunked_decoder_unit (
	input  logic      clk,
	input  logic      arst_n,
	chd_in_if.sink    din,
	chd_out_if.source dout
);

	chd_pkg::dec_result_t result;
	logic                 can_take;
	logic                 accept;

	assign din.ready = can_take;
	assign accept    = din.valid && can_take;

	chd_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.op        (din.op),
		.data_byte (din.data_byte),
		.result    (result)
	);

	chd_out_reg u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.result   (result),
		.can_take (can_take),
		.dout     (dout)
	);

endmodule

/* sv/chd_core.sv */
// Decoder state register and combinational next-state and result logic.
module chd_core (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 accept,
	input  logic                 op,
	input  logic [7:0]           data_byte,
	output chd_pkg::dec_result_t result
);

	chd_pkg::dec_state_t state_q;
	chd_pkg::dec_state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= chd_pkg::STATE_RESET;
		end else if (accept) begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt       = state_q;
		result.vld      = 1'b0;
		result.kind     = chd_pkg::KIND_DATA;
		result.out_byte = 8'd0;
		result.status   = chd_pkg::ST_OK;
		if (op == chd_pkg::OP_END) begin
			result.vld    = accept;
			result.kind   = chd_pkg::KIND_STATUS;
			result.status = chd_pkg::end_status(state_q);
			state_nxt     = chd_pkg::STATE_RESET;
		end else if (state_q.error_code == chd_pkg::ST_OK) begin
			unique case (state_q.phase)
				chd_pkg::PH_START, chd_pkg::PH_LINE: begin
					state_nxt = chd_pkg::line_byte(state_q, data_byte);
				end
				chd_pkg::PH_LINE_CR: begin
					if (data_byte == chd_pkg::CH_LF) begin
						state_nxt = chd_pkg::close_size_line(state_q);
					end else begin
						state_nxt = state_q;
						if (!state_q.in_extension) begin
							state_nxt.line_bad = 1'b1;
						end
						state_nxt = chd_pkg::line_byte(state_nxt, data_byte);
					end
				end
				chd_pkg::PH_DATA: begin
					result.vld      = accept;
					result.out_byte = data_byte;
					state_nxt.chunk_remaining = state_q.chunk_remaining - 1'b1;
					if (state_q.chunk_remaining == chd_pkg::LEN_BITS'(1)) begin
						state_nxt.phase = chd_pkg::PH_DATA_CR;
					end
				end
				chd_pkg::PH_DATA_CR: begin
					if (data_byte == chd_pkg::CH_CR) begin
						state_nxt.phase = chd_pkg::PH_DATA_LF;
					end else begin
						state_nxt.error_code = chd_pkg::ST_NO_TERM;
					end
				end
				chd_pkg::PH_DATA_LF: begin
					if (data_byte == chd_pkg::CH_LF) begin
						state_nxt.phase = chd_pkg::PH_START;
					end else begin
						state_nxt.error_code = chd_pkg::ST_NO_TERM;
					end
				end
				chd_pkg::PH_FINAL: begin
					state_nxt = chd_pkg::final_byte(state_q, data_byte);
				end
				default: begin
					state_nxt = state_q;
				end
			endcase
		end
	end

endmodule

/* sv/chd_out_reg.sv */
// Output word register between the decoder and the output channel.
module chd_out_reg (
	input  logic                 clk,
	input  logic                 arst_n,
	input  chd_pkg::dec_result_t result,
	output logic                 can_take,
	chd_out_if.source            dout
);

	logic             valid_q;
	logic             kind_q;
	logic [7:0]       byte_q;
	chd_pkg::status_t status_q;

	assign can_take = !valid_q || dout.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (can_take) begin
			valid_q <= result.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (can_take && result.vld) begin
			kind_q   <= result.kind;
			byte_q   <= result.out_byte;
			status_q <= result.status;
		end
	end

	assign dout.valid    = valid_q;
	assign dout.kind     = kind_q;
	assign dout.out_byte = byte_q;
	assign dout.status   = status_q;

endmodule
